// ===== hw/rtl/gfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Geofence alarm check package
// Shared widths, codes, state types and divider status for the fence checker.
// ----------------------------------------------------------------------------
package gfa_pkg;

   localparam int DEF_MAX_SHAPES   = 8;
   localparam int DEF_MAX_VERTICES = 16;

   localparam int COORD_W    = 14;
   localparam int VTX_W      = 13;
   localparam int BOX_W      = 12;
   localparam int PROD_W     = 27;
   localparam int MUL_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam int MIN_POLY_VERTS = 3;
   localparam int RECT_CORNERS   = 2;

   typedef enum logic [1:0] {
      OP_VERTEX = 2'd0,
      OP_SHAPE  = 2'd1,
      OP_CHECK  = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      CSR_VIDEO_WIDTH    = 3'd0,
      CSR_VIDEO_HEIGHT   = 3'd1,
      CSR_MODEL_WIDTH    = 3'd2,
      CSR_MODEL_HEIGHT   = 3'd3,
      CSR_OVERLAY_WIDTH  = 3'd4,
      CSR_OVERLAY_HEIGHT = 3'd5,
      CSR_ALARM_INSIDE   = 3'd6,
      CSR_FENCE_ENABLE   = 3'd7
   } csr_idx_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_DIV_GO,
      S_DIV_WAIT,
      S_SHAPE,
      S_VADDR,
      S_VLOAD,
      S_VUSE,
      S_EDGE_L,
      S_EDGE_R,
      S_EDGE_C,
      S_DONE
   } ctrl_state_type;

   typedef enum logic [2:0] {
      JOB_LEFT,
      JOB_RIGHT,
      JOB_BOTTOM,
      JOB_VX,
      JOB_VY
   } div_job_type;

   typedef enum logic {
      DIV_IDLE,
      DIV_RUN
   } div_state_type;

   typedef struct packed {
      logic               start;
      logic [PROD_W-1:0]  dividend;
      logic [COORD_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [COORD_W-1:0] quot;
   } div_rsp_type;

endpackage

// ===== hw/rtl/gfa_if.sv =====
// ----------------------------------------------------------------------------
// Geofence alarm check channels
// Request and response word channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface gfa_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [2:0]  shape_slot;
   logic [3:0]  vertex_slot;
   logic [12:0] vertex_x;
   logic [12:0] vertex_y;
   logic        shape_used;
   logic        shape_is_rect;
   logic [4:0]  shape_vertices;
   logic [11:0] box_left;
   logic [11:0] box_right;
   logic [11:0] box_bottom;

   modport source (
      output valid, opcode, shape_slot, vertex_slot, vertex_x, vertex_y,
             shape_used, shape_is_rect, shape_vertices, box_left, box_right,
             box_bottom,
      input  ready
   );
   modport sink (
      input  valid, opcode, shape_slot, vertex_slot, vertex_x, vertex_y,
             shape_used, shape_is_rect, shape_vertices, box_left, box_right,
             box_bottom,
      output ready
   );
endinterface

interface gfa_rsp_if;
   logic        valid;
   logic        ready;
   logic        alarm;
   logic        inside_any_fence;
   logic [13:0] foot_x;
   logic [13:0] foot_y;

   modport source (
      output valid, alarm, inside_any_fence, foot_x, foot_y,
      input  ready
   );
   modport sink (
      input  valid, alarm, inside_any_fence, foot_x, foot_y,
      output ready
   );
endinterface

// ===== hw/rtl/geofence_alarm_check.sv =====
// ----------------------------------------------------------------------------
// Geofence alarm check
// Fence shape store and sequenced point-in-fence test for detection boxes.
// ----------------------------------------------------------------------------
// One word is taken at a time; req_if.ready is high only while the sequencer
// is idle, and a finished result may wait in the output register while the
// next word is taken. Vertex and shape writes land in the decode state. A
// check maps the box with three multiply-divides on the one-bit-a-cycle
// divider (all ones without iterating on saturation), then walks the present
// shapes: each loaded vertex is addressed, read and used (two more divides
// with overlay rescaling on); an edge straddling the foot point row adds two
// products and a compare. A polygon of n vertices loads n+1, a rectangle two.
// Shapes after the first hit are only scanned. One signed 16x16 multiplier
// and one divider are shared by every step. There is no clearing pass: vertex
// memory is undefined until written, shape descriptors reset to absent.
// ----------------------------------------------------------------------------
module geofence_alarm_check
   import gfa_pkg::*;
#(
   parameter int MAX_SHAPES   = DEF_MAX_SHAPES,
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
)(
   input  logic                  clock,
   input  logic                  reset,
   gfa_req_if.sink               req_if,
   gfa_rsp_if.source             rsp_if,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int SHW   = (MAX_SHAPES > 1) ? $clog2(MAX_SHAPES) : 1;
   localparam int TW    = $clog2(MAX_SHAPES + 1);
   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int CW    = $clog2(MAX_VERTICES + 1);
   localparam int DEPTH = MAX_SHAPES * MAX_VERTICES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration registers
   logic [13:0] vid_w_ff, vid_h_ff, ovl_w_ff, ovl_h_ff;
   logic [12:0] mdl_w_ff, mdl_h_ff;
   logic        alarm_in_ff, fence_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vid_w_ff    <= 14'd1920;
         vid_h_ff    <= 14'd1080;
         mdl_w_ff    <= 13'd640;
         mdl_h_ff    <= 13'd640;
         ovl_w_ff    <= '0;
         ovl_h_ff    <= '0;
         alarm_in_ff <= 1'b1;
         fence_en_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_idx_type'(csr_index))
            CSR_VIDEO_WIDTH:    vid_w_ff    <= csr_wdata;
            CSR_VIDEO_HEIGHT:   vid_h_ff    <= csr_wdata;
            CSR_MODEL_WIDTH:    mdl_w_ff    <= csr_wdata[12:0];
            CSR_MODEL_HEIGHT:   mdl_h_ff    <= csr_wdata[12:0];
            CSR_OVERLAY_WIDTH:  ovl_w_ff    <= csr_wdata;
            CSR_OVERLAY_HEIGHT: ovl_h_ff    <= csr_wdata;
            CSR_ALARM_INSIDE:   alarm_in_ff <= csr_wdata[0];
            CSR_FENCE_ENABLE:   fence_en_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // latched request word
   logic [1:0]  op_ff;
   logic [2:0]  slot_ff;
   logic [3:0]  vslot_ff;
   logic [12:0] vx_ff, vy_ff;
   logic        used_ff, rect_ff;
   logic [4:0]  nv_ff;
   logic [11:0] bl_ff, br_ff, bb_ff;

   logic req_fire;
   assign req_fire = req_if.valid & req_if.ready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_if.opcode;
         slot_ff  <= req_if.shape_slot;
         vslot_ff <= req_if.vertex_slot;
         vx_ff    <= req_if.vertex_x;
         vy_ff    <= req_if.vertex_y;
         used_ff  <= req_if.shape_used;
         rect_ff  <= req_if.shape_is_rect;
         nv_ff    <= req_if.shape_vertices;
         bl_ff    <= req_if.box_left;
         br_ff    <= req_if.box_right;
         bb_ff    <= req_if.box_bottom;
      end
   end

   // sequencer registers
   ctrl_state_type      state_ff, state_in;
   div_job_type         job_ff, job_in;
   logic [COORD_W-1:0]  l_ff, l_in;
   logic [COORD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [TW-1:0]       t_ff, t_in;
   logic [VW-1:0]       vk_ff, vk_in;
   logic                first_ff, first_in;
   logic [COORD_W-1:0]  cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [COORD_W-1:0]  prv_x_ff, prv_x_in, prv_y_ff, prv_y_in;
   logic signed [31:0]  lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic                dpos_ff, dpos_in;
   logic                sin_ff, sin_in;
   logic                any_ff, any_in;
   logic                inside_ff, inside_in;

   // output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_alarm_ff, rsp_alarm_in;
   logic                rsp_inside_ff, rsp_inside_in;
   logic [COORD_W-1:0]  rsp_fx_ff, rsp_fx_in, rsp_fy_ff, rsp_fy_in;

   // shape descriptors, reset to absent
   logic          present_ff [MAX_SHAPES];
   logic          isrect_ff  [MAX_SHAPES];
   logic [CW-1:0] count_ff   [MAX_SHAPES];

   // vertex memory, undefined until written
   logic [VTX_W-1:0] mem_x [DEPTH];
   logic [VTX_W-1:0] mem_y [DEPTH];
   logic [VTX_W-1:0] rd_x_ff, rd_y_ff;

   // shared units
   div_req_type         div_req;
   div_rsp_type         div_rsp;
   logic signed [MUL_W-1:0] mul_a, mul_b;
   logic signed [31:0]  mul_p;

   gfa_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign mul_p = mul_a * mul_b;

   // decode helpers
   logic          is_check, wr_vtx, wr_shape;
   logic          slot_ok, vslot_ok;
   logic [SHW-1:0] wr_sidx, t_idx;
   logic [CW-1:0]  nv_sat, n_cur;
   logic [VW-1:0]  last_k, vidx;
   logic [AW-1:0]  wr_addr, rd_addr;
   logic          rescale;
   logic          crosses, edge_flip, rect_hit, shape_ok;
   logic [COORD_W:0] foot_sum;
   logic [COORD_W-1:0] lo_x, hi_x, lo_y, hi_y;

   always_comb begin
      is_check = opcode_type'(op_ff) == OP_CHECK;
      slot_ok  = 32'(slot_ff) < MAX_SHAPES;
      vslot_ok = 32'(vslot_ff) < MAX_VERTICES;
      wr_vtx   = (state_ff == S_DECODE) && (opcode_type'(op_ff) == OP_VERTEX)
                 && slot_ok && vslot_ok;
      wr_shape = (state_ff == S_DECODE) && (opcode_type'(op_ff) == OP_SHAPE) && slot_ok;
      wr_sidx  = SHW'(slot_ff);
      nv_sat   = (32'(nv_ff) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(nv_ff);
      wr_addr  = AW'(wr_sidx) * AW'(MAX_VERTICES) + AW'(vslot_ff);

      t_idx    = t_ff[SHW-1:0];
      n_cur    = count_ff[t_idx];
      last_k   = VW'(n_cur - CW'(1));
      vidx     = first_ff ? last_k : vk_ff;
      rd_addr  = AW'(t_idx) * AW'(MAX_VERTICES) + AW'(vidx);
      rescale  = (ovl_w_ff != '0) && (ovl_h_ff != '0);

      // rectangle needs two corners, polygon three
      shape_ok = isrect_ff[t_idx] ? (n_cur >= CW'(RECT_CORNERS))
                                  : (n_cur >= CW'(MIN_POLY_VERTS));

      crosses   = (cur_y_ff > py_ff) != (prv_y_ff > py_ff);
      edge_flip = dpos_ff ? (lhs_ff < rhs_ff) : (lhs_ff > rhs_ff);

      lo_x = (prv_x_ff < cur_x_ff) ? prv_x_ff : cur_x_ff;
      hi_x = (prv_x_ff < cur_x_ff) ? cur_x_ff : prv_x_ff;
      lo_y = (prv_y_ff < cur_y_ff) ? prv_y_ff : cur_y_ff;
      hi_y = (prv_y_ff < cur_y_ff) ? cur_y_ff : prv_y_ff;
      rect_hit = (px_ff >= lo_x) && (px_ff <= hi_x) && (py_ff >= lo_y) && (py_ff <= hi_y);

      foot_sum = {1'b0, l_ff} + {1'b0, div_rsp.quot};
   end

   // shared multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_DIV_GO: begin
            case (job_ff)
               JOB_LEFT:   begin mul_a = MUL_W'(bl_ff);    mul_b = MUL_W'(vid_w_ff); end
               JOB_RIGHT:  begin mul_a = MUL_W'(br_ff);    mul_b = MUL_W'(vid_w_ff); end
               JOB_BOTTOM: begin mul_a = MUL_W'(bb_ff);    mul_b = MUL_W'(vid_h_ff); end
               JOB_VX:     begin mul_a = MUL_W'(cur_x_ff); mul_b = MUL_W'(vid_w_ff); end
               JOB_VY:     begin mul_a = MUL_W'(cur_y_ff); mul_b = MUL_W'(vid_h_ff); end
               default: ;
            endcase
         end
         S_EDGE_L: begin
            // (px - xi) * (yj - yi)
            mul_a = $signed(MUL_W'(px_ff)) - $signed(MUL_W'(cur_x_ff));
            mul_b = $signed(MUL_W'(prv_y_ff)) - $signed(MUL_W'(cur_y_ff));
         end
         S_EDGE_R: begin
            // (xj - xi) * (py - yi)
            mul_a = $signed(MUL_W'(prv_x_ff)) - $signed(MUL_W'(cur_x_ff));
            mul_b = $signed(MUL_W'(py_ff)) - $signed(MUL_W'(cur_y_ff));
         end
         default: ;
      endcase
   end

   always_comb begin
      div_req.start    = state_ff == S_DIV_GO;
      div_req.dividend = mul_p[PROD_W-1:0];
      case (job_ff)
         JOB_LEFT, JOB_RIGHT: div_req.divisor = COORD_W'(mdl_w_ff);
         JOB_BOTTOM:          div_req.divisor = COORD_W'(mdl_h_ff);
         JOB_VX:              div_req.divisor = ovl_w_ff;
         JOB_VY:              div_req.divisor = ovl_h_ff;
         default:             div_req.divisor = COORD_W'(1);
      endcase
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      job_in        = job_ff;
      l_in          = l_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      t_in          = t_ff;
      vk_in         = vk_ff;
      first_in      = first_ff;
      cur_x_in      = cur_x_ff;
      cur_y_in      = cur_y_ff;
      prv_x_in      = prv_x_ff;
      prv_y_in      = prv_y_ff;
      lhs_in        = lhs_ff;
      rhs_in        = rhs_ff;
      dpos_in       = dpos_ff;
      sin_in        = sin_ff;
      any_in        = any_ff;
      inside_in     = inside_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_if.ready;
      rsp_alarm_in  = rsp_alarm_ff;
      rsp_inside_in = rsp_inside_ff;
      rsp_fx_in     = rsp_fx_ff;
      rsp_fy_in     = rsp_fy_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_fire) state_in = S_DECODE;
         end
         S_DECODE: begin
            // writes land in the stores this cycle
            if (is_check) begin
               job_in   = JOB_LEFT;
               state_in = S_DIV_GO;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DIV_GO: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_rsp.done) begin
               case (job_ff)
                  JOB_LEFT: begin
                     l_in     = div_rsp.quot;
                     job_in   = JOB_RIGHT;
                     state_in = S_DIV_GO;
                  end
                  JOB_RIGHT: begin
                     px_in    = foot_sum[COORD_W:1];
                     job_in   = JOB_BOTTOM;
                     state_in = S_DIV_GO;
                  end
                  JOB_BOTTOM: begin
                     py_in     = div_rsp.quot;
                     t_in      = '0;
                     any_in    = 1'b0;
                     inside_in = 1'b0;
                     state_in  = S_SHAPE;
                  end
                  JOB_VX: begin
                     cur_x_in = div_rsp.quot;
                     job_in   = JOB_VY;
                     state_in = S_DIV_GO;
                  end
                  JOB_VY: begin
                     cur_y_in = div_rsp.quot;
                     state_in = S_VUSE;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SHAPE: begin
            if (t_ff == TW'(MAX_SHAPES)) begin
               state_in = S_DONE;
            end else if (!present_ff[t_idx]) begin
               t_in = t_ff + TW'(1);
            end else begin
               any_in = 1'b1;
               if (!inside_ff && shape_ok) begin
                  vk_in    = '0;
                  first_in = !isrect_ff[t_idx];
                  sin_in   = 1'b0;
                  state_in = S_VADDR;
               end else begin
                  t_in = t_ff + TW'(1);
               end
            end
         end
         S_VADDR: begin
            state_in = S_VLOAD;
         end
         S_VLOAD: begin
            cur_x_in = COORD_W'(rd_x_ff);
            cur_y_in = COORD_W'(rd_y_ff);
            if (rescale) begin
               job_in   = JOB_VX;
               state_in = S_DIV_GO;
            end else begin
               state_in = S_VUSE;
            end
         end
         S_VUSE: begin
            prv_x_in = cur_x_ff;
            prv_y_in = cur_y_ff;
            if (isrect_ff[t_idx]) begin
               if (vk_ff == '0) begin
                  vk_in    = VW'(1);
                  state_in = S_VADDR;
               end else begin
                  inside_in = rect_hit;
                  t_in      = t_ff + TW'(1);
                  state_in  = S_SHAPE;
               end
            end else if (first_ff) begin
               // closing vertex loaded, edges start at vertex zero
               first_in = 1'b0;
               state_in = S_VADDR;
            end else if (crosses) begin
               prv_x_in = prv_x_ff;
               prv_y_in = prv_y_ff;
               state_in = S_EDGE_L;
            end else if (vk_ff == last_k) begin
               inside_in = sin_ff;
               t_in      = t_ff + TW'(1);
               state_in  = S_SHAPE;
            end else begin
               vk_in    = vk_ff + VW'(1);
               state_in = S_VADDR;
            end
         end
         S_EDGE_L: begin
            lhs_in   = mul_p;
            dpos_in  = prv_y_ff > cur_y_ff;
            state_in = S_EDGE_R;
         end
         S_EDGE_R: begin
            rhs_in   = mul_p;
            state_in = S_EDGE_C;
         end
         S_EDGE_C: begin
            sin_in   = sin_ff ^ edge_flip;
            prv_x_in = cur_x_ff;
            prv_y_in = cur_y_ff;
            if (vk_ff == last_k) begin
               inside_in = sin_ff ^ edge_flip;
               t_in      = t_ff + TW'(1);
               state_in  = S_SHAPE;
            end else begin
               vk_in    = vk_ff + VW'(1);
               state_in = S_VADDR;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = is_check && fence_en_ff && any_ff && inside_ff;
               rsp_alarm_in  = is_check && fence_en_ff && any_ff
                               && (alarm_in_ff ? inside_ff : !inside_ff);
               rsp_fx_in     = is_check ? px_ff : '0;
               rsp_fy_in     = is_check ? py_ff : '0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      job_ff        <= job_in;
      l_ff          <= l_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      t_ff          <= t_in;
      vk_ff         <= vk_in;
      first_ff      <= first_in;
      cur_x_ff      <= cur_x_in;
      cur_y_ff      <= cur_y_in;
      prv_x_ff      <= prv_x_in;
      prv_y_ff      <= prv_y_in;
      lhs_ff        <= lhs_in;
      rhs_ff        <= rhs_in;
      dpos_ff       <= dpos_in;
      sin_ff        <= sin_in;
      any_ff        <= any_in;
      inside_ff     <= inside_in;
      rsp_alarm_ff  <= rsp_alarm_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_fx_ff     <= rsp_fx_in;
      rsp_fy_ff     <= rsp_fy_in;
   end

   // descriptor table
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_SHAPES; i++) begin
            present_ff[i] <= 1'b0;
            isrect_ff[i]  <= 1'b0;
            count_ff[i]   <= '0;
         end
      end else if (wr_shape) begin
         present_ff[wr_sidx] <= used_ff;
         isrect_ff[wr_sidx]  <= rect_ff;
         count_ff[wr_sidx]   <= nv_sat;
      end
   end

   // vertex memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_vtx) begin
         mem_x[wr_addr] <= vx_ff;
         mem_y[wr_addr] <= vy_ff;
      end
      if (state_ff == S_VADDR) begin
         rd_x_ff <= mem_x[rd_addr];
         rd_y_ff <= mem_y[rd_addr];
      end
   end

   assign req_if.ready            = state_ff == S_IDLE;
   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.alarm            = rsp_alarm_ff;
   assign rsp_if.inside_any_fence = rsp_inside_ff;
   assign rsp_if.foot_x           = rsp_fx_ff;
   assign rsp_if.foot_y           = rsp_fy_ff;

   // divider answers only the job it was started for
   a_div_done_wait: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == S_DIV_WAIT)
      else $error("divider done outside wait state");

   // vertex fetch only for a real shape slot
   a_vaddr_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_VADDR |-> (t_ff < TW'(MAX_SHAPES)) && present_ff[t_idx])
      else $error("vertex fetch for missing shape");

   // accepted word always gets decoded next
   a_accept_decode: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_DECODE)
      else $error("accepted word not decoded");

   // shape scan ends in the result stage
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHAPE) && (t_ff == TW'(MAX_SHAPES)) |=> state_ff == S_DONE)
      else $error("shape scan did not finish");

endmodule

// ===== hw/rtl/gfa_div.sv =====
// ----------------------------------------------------------------------------
// Geofence scaling divider
// Restoring divider, one quotient bit a cycle, quotient saturated at 14 bits.
// ----------------------------------------------------------------------------
module gfa_div
   import gfa_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(COORD_W);

   div_state_type      state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [COORD_W-1:0] den_ff, den_in;
   logic [COORD_W-1:0] rem_ff, rem_in;
   logic [COORD_W-1:0] low_ff, low_in;
   logic [COORD_W-1:0] quot_ff, quot_in;
   logic               done_ff, done_in;

   logic [COORD_W-1:0] den_start;
   logic [COORD_W:0]   trial;
   logic               ge;
   logic [COORD_W:0]   diff;
   logic               ovf;

   always_comb begin
      // zero divisor is taken as one
      den_start = (div_req.divisor == '0) ? COORD_W'(1) : div_req.divisor;
      ovf       = {1'b0, div_req.dividend} >= {den_start, {COORD_W{1'b0}}};
      trial     = {rem_ff, low_ff[COORD_W-1]};
      ge        = trial >= {1'b0, den_ff};
      diff      = trial - {1'b0, den_ff};

      state_in = state_ff;
      cnt_in   = cnt_ff;
      den_in   = den_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quot_in  = quot_ff;
      done_in  = 1'b0;

      case (state_ff)
         DIV_IDLE: begin
            if (div_req.start) begin
               den_in = den_start;
               if (ovf) begin
                  quot_in = '1;
                  done_in = 1'b1;
               end else begin
                  rem_in   = {1'b0, div_req.dividend[PROD_W-1:COORD_W]};
                  low_in   = div_req.dividend[COORD_W-1:0];
                  cnt_in   = '0;
                  state_in = DIV_RUN;
               end
            end
         end
         DIV_RUN: begin
            rem_in  = ge ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            low_in  = {low_ff[COORD_W-2:0], 1'b0};
            quot_in = {quot_ff[COORD_W-2:0], ge};
            cnt_in  = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(COORD_W - 1)) begin
               done_in  = 1'b1;
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      cnt_ff  <= cnt_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      low_ff  <= low_in;
      quot_ff <= quot_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;

endmodule
